// ===== sv/ialu_pkg.sv =====
// shared types and constants for the integer alu with prime test
// no dependencies; imported by every module of the block
package ialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // operation codes
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_EVEN  = 3'd5;
    localparam logic [2:0] OP_PRIME = 3'd6;

    // status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_DIVZERO = 2'd2;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic [1:0]                   status;
    } resp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_MUL_END,
        S_DIV_WAIT,
        S_PRIME_GO,
        S_PRIME_WAIT,
        S_OUT
    } state_t;

    typedef enum logic {
        SRC_OPERANDS,
        SRC_PRIME
    } div_src_t;

    typedef enum logic [2:0] {
        RES_SIMPLE,
        RES_PRODUCT,
        RES_QUOTIENT,
        RES_PRIME,
        RES_COMPOSITE
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_step;
        logic     div_go;
        div_src_t div_src;
        logic     d_inc;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       div_zero;
        logic       prime_trivial;
        logic       mul_last;
        logic       div_done;
        logic       prime_exceed;
        logic       rem_zero;
    } dp_status_t;

endpackage

// ===== sv/integer_alu_with_prime_test.sv =====
// top level of the integer alu with trial-division prime test
// depends on ialu_pkg, ialu_ctrl, ialu_dp (which holds ialu_div)

// One request at a time: a request is taken on a rising edge with start high
// and busy low; busy then stays high until the answer has been shown. The
// answer sits on resp for exactly one cycle with done high and must be taken
// then, since the receiver cannot stall the block. Add, sub, even, an invalid
// opcode and divide by zero are answered at decode; multiply is shift-add, one
// multiplier bit per cycle; divide uses a radix-2 divider, one quotient bit per
// cycle. The prime test reuses the divider once per trial divisor, so a 32-bit
// prime near the top of the range takes about 46340 divisions; values below 2
// answer without a division.
module integer_alu_with_prime_test (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ialu_pkg::req_t   req,
    output logic             done,
    output ialu_pkg::resp_t  resp
);
    import ialu_pkg::*;

    // command and status between controller and datapath
    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // sequencing of each request
    ialu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // operands, arithmetic units and the result register
    ialu_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .resp  (resp)
    );

endmodule

// ===== sv/ialu_div.sv =====
// radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on ialu_pkg for the data width
module ialu_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ialu_pkg::DATA_WIDTH-1:0]  dividend,
    input  logic [ialu_pkg::DATA_WIDTH-1:0]  divisor,
    output logic                             done,
    output logic [ialu_pkg::DATA_WIDTH-1:0]  quotient,
    output logic [ialu_pkg::DATA_WIDTH-1:0]  remainder
);
    import ialu_pkg::*;

    localparam int W = DATA_WIDTH;

    logic             running_reg, running_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0]       shifted;
    logic [W+1:0]     trial;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign ge      = ~trial[W+1];

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = dividend;
            dvs_next     = divisor;
        end
        else if (running_reg)
        begin
            rem_next = ge ? trial[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W-1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/ialu_dp.sv =====
// datapath: operand registers, shift-add multiplier, divider, trial divisor, result
// depends on ialu_pkg and ialu_div
module ialu_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ialu_pkg::req_t         req,
    input  ialu_pkg::ctrl_cmd_t    cmd,
    output ialu_pkg::dp_status_t   stat,
    output ialu_pkg::resp_t        resp
);
    import ialu_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [2:0]       op_reg;
    logic [W-1:0]     a_reg, b_reg;
    logic [W-1:0]     mcand_reg, mplier_reg, prod_reg;
    logic [CNT_W-1:0] mcnt_reg;
    logic [W-1:0]     d_reg;
    logic [W-1:0]     result_reg, result_next;
    logic [1:0]       status_reg, status_next;

    logic [W-1:0]     mag_a, mag_b;
    logic [W-1:0]     div_dividend, div_divisor;
    logic             div_done;
    logic [W-1:0]     quotient, remainder;
    logic [W-1:0]     simple_res;
    logic [1:0]       simple_sts;

    assign mag_a = a_reg[W-1] ? ('0 - a_reg) : a_reg;
    assign mag_b = b_reg[W-1] ? ('0 - b_reg) : b_reg;

    assign div_dividend = (cmd.div_src == SRC_PRIME) ? a_reg : mag_a;
    assign div_divisor  = (cmd.div_src == SRC_PRIME) ? d_reg : mag_b;

    ialu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // combinational answers for add, sub, even, invalid opcode and divide by zero
    always_comb
    begin
        simple_sts = STS_OK;
        case (op_reg)
            OP_ADD:  simple_res = a_reg + b_reg;
            OP_SUB:  simple_res = a_reg - b_reg;
            OP_DIV:
            begin
                simple_res = '0;
                simple_sts = STS_DIVZERO;
            end
            OP_EVEN: simple_res = {{(W-1){1'b0}}, ~a_reg[0]};
            default:
            begin
                simple_res = '1;
                simple_sts = STS_INVALID;
            end
        endcase
    end

    always_comb
    begin
        result_next = result_reg;
        status_next = status_reg;
        if (cmd.res_load)
        begin
            status_next = STS_OK;
            case (cmd.res_sel)
                RES_SIMPLE:
                begin
                    result_next = simple_res;
                    status_next = simple_sts;
                end
                RES_PRODUCT:  result_next = prod_reg;
                RES_QUOTIENT: result_next = (a_reg[W-1] ^ b_reg[W-1]) ? ('0 - quotient)
                                                                       : quotient;
                RES_PRIME:    result_next = {{(W-1){1'b0}}, 1'b1};
                default:      result_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            mcnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            mcnt_reg <= mcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req.op;
            a_reg      <= req.operand_a;
            b_reg      <= req.operand_b;
            mcand_reg  <= req.operand_a;
            mplier_reg <= req.operand_b;
            prod_reg   <= '0;
            d_reg      <= W'(2);
        end
        else
        begin
            if (cmd.mul_step)
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[W-1:1]};
            end
            if (cmd.d_inc)
            begin
                d_reg <= d_reg + 1'b1;
            end
        end
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign stat.op            = op_reg;
    assign stat.div_zero      = (b_reg == '0);
    assign stat.prime_trivial = a_reg[W-1] || (a_reg[W-1:1] == '0);
    assign stat.mul_last      = (mcnt_reg == CNT_W'(W-1));
    assign stat.div_done      = div_done;
    assign stat.prime_exceed  = (d_reg > quotient);
    assign stat.rem_zero      = (remainder == '0);

    assign resp.result = result_reg;
    assign resp.status = status_reg;

endmodule

// ===== sv/ialu_ctrl.sv =====
// controller state machine: sequences decode, multiply, divide and trial division
// depends on ialu_pkg
module ialu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ialu_pkg::dp_status_t  stat,
    output ialu_pkg::ctrl_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import ialu_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_MUL:   state_next = S_MUL;
                    OP_DIV:   state_next = stat.div_zero ? S_OUT : S_DIV_WAIT;
                    OP_PRIME: state_next = stat.prime_trivial ? S_OUT : S_PRIME_WAIT;
                    default:  state_next = S_OUT;
                endcase
            end
            S_MUL:
            begin
                if (stat.mul_last)
                begin
                    state_next = S_MUL_END;
                end
            end
            S_MUL_END: state_next = S_OUT;
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_PRIME_GO: state_next = S_PRIME_WAIT;
            S_PRIME_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = (stat.prime_exceed || stat.rem_zero) ? S_OUT : S_PRIME_GO;
                end
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.div_src  = SRC_OPERANDS;
        cmd.res_sel  = RES_SIMPLE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_MUL: ;
                    OP_DIV:
                    begin
                        cmd.div_go   = ~stat.div_zero;
                        cmd.res_load = stat.div_zero;
                    end
                    OP_PRIME:
                    begin
                        cmd.div_src  = SRC_PRIME;
                        cmd.div_go   = ~stat.prime_trivial;
                        cmd.res_load = stat.prime_trivial;
                        cmd.res_sel  = RES_COMPOSITE;
                    end
                    default: cmd.res_load = 1'b1;
                endcase
            end
            S_MUL: cmd.mul_step = 1'b1;
            S_MUL_END:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_PRODUCT;
            end
            S_DIV_WAIT:
            begin
                cmd.res_load = stat.div_done;
                cmd.res_sel  = RES_QUOTIENT;
            end
            S_PRIME_GO:
            begin
                cmd.div_src = SRC_PRIME;
                cmd.div_go  = 1'b1;
            end
            S_PRIME_WAIT:
            begin
                cmd.div_src = SRC_PRIME;
                if (stat.div_done)
                begin
                    if (stat.prime_exceed)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_PRIME;
                    end
                    else if (stat.rem_zero)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_COMPOSITE;
                    end
                    else
                    begin
                        cmd.d_inc = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule
